// ----- rtl/double_threshold_hysteresis_assert.svh -----
// Assertion macros shared by the hysteresis block's modules.
// Uses the module's clk and rst_n; no other dependencies.
`ifndef DOUBLE_THRESHOLD_HYSTERESIS_ASSERT_SVH
`define DOUBLE_THRESHOLD_HYSTERESIS_ASSERT_SVH

// same-cycle implication
`define DTH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dth_pkg.sv -----
// Shared types, constants and helpers for the double-threshold hysteresis block.
// No dependencies.
package dth_pkg;

  localparam int MAX_WIDTH_DEF   = 2048;
  localparam int MAX_HEIGHT      = 2048;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int ROW_W           = 12;   // input row counter, reaches height+1 in drain
  localparam int OUT_ROW_W       = 11;   // output row counter, below height
  localparam int DIM_W           = 14;   // wide enough for any clamp limit

  localparam logic [8:0]  LOW_RST    = 9'd20;
  localparam logic [8:0]  HIGH_RST   = 9'd50;
  localparam logic [7:0]  STRONG_RST = 8'd255;
  localparam logic [7:0]  WEAK_RST   = 8'd128;
  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;

  typedef enum logic [2:0] {
    REG_LOW    = 3'd0,
    REG_HIGH   = 3'd1,
    REG_STRONG = 3'd2,
    REG_WEAK   = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } cfg_reg_t;

  // first-pass class; the back maps it onto the configured mark values
  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_WEAK   = 2'd1,
    CLS_STRONG = 2'd2
  } cls_code_t;

  // one classified word on its way from front to back
  typedef struct packed {
    cls_code_t  cls;       // first-pass class
    logic       up1_ok;    // row above exists
    logic       up2_ok;    // row two above exists
    logic       emit;      // this word releases a result
    logic       interior;  // result position is off the border
    logic       last;      // result is the final pixel of the frame
  } item_t;

  // zero acts as one, anything above lim acts as lim
  function automatic logic [DIM_W-1:0] clamp_dim(logic [11:0] v, logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] res;
    if (v == 12'd0) begin
      res = DIM_W'(1);
    end else if (DIM_W'(v) > lim) begin
      res = lim;
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

endpackage

// ----- rtl/dth_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dth_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/dth_front.sv -----
// Front end: accepts input words, classifies pixels and tracks frame position.
// Depends on dth_pkg and the assertion header.
`include "double_threshold_hysteresis_assert.svh"
module dth_front #(
  parameter int MAX_WIDTH = dth_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                pixel_value,
  input  logic                      drain,
  input  logic [8:0]                low_thr,
  input  logic [8:0]                high_thr,
  input  logic [CW:0]               width,
  input  logic [11:0]               height,
  input  logic                      q_full,
  output logic                      push,
  output dth_pkg::item_t            push_item,
  output logic [CW-1:0]             push_col
);

  logic [CW-1:0]                  in_col_r, in_col_nxt;
  logic [dth_pkg::ROW_W-1:0]      in_row_r, in_row_nxt;
  logic [CW-1:0]                  out_col_r, out_col_nxt;
  logic [dth_pkg::OUT_ROW_W-1:0]  out_row_r, out_row_nxt;

  logic accept, drain_phase, ignore, in_col_end, out_col_end, out_row_end;
  dth_pkg::cls_code_t cls_code;
  dth_pkg::item_t item;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  assign drain_phase = in_row_r >= height;
  assign ignore      = drain && !drain_phase;

  // classification happens at the thresholds; the mark values are applied in the back
  always_comb begin
    if (drain_phase) begin
      cls_code = dth_pkg::CLS_NONE;
    end else if ({1'b0, pixel_value} >= high_thr) begin
      cls_code = dth_pkg::CLS_STRONG;
    end else if ({1'b0, pixel_value} >= low_thr) begin
      cls_code = dth_pkg::CLS_WEAK;
    end else begin
      cls_code = dth_pkg::CLS_NONE;
    end
  end

  assign in_col_end  = ((CW+1)'({1'b0, in_col_r}) + (CW+1)'(1)) >= width;
  assign out_col_end = ((CW+1)'({1'b0, out_col_r}) + (CW+1)'(1)) >= width;
  assign out_row_end = (12'({1'b0, out_row_r}) + 12'd1) >= height;

  always_comb begin
    item.up1_ok   = in_row_r != '0;
    item.up2_ok   = in_row_r >= dth_pkg::ROW_W'(2);
    item.emit     = (in_row_r >= dth_pkg::ROW_W'(2)) ||
                    ((in_row_r == dth_pkg::ROW_W'(1)) && (in_col_r != '0));
    item.interior = (out_row_r != '0) &&
                    ((12'({1'b0, out_row_r}) + 12'd2) <= height) &&
                    (out_col_r != '0) &&
                    (((CW+1)'({1'b0, out_col_r}) + (CW+1)'(2)) <= width);
    item.last     = out_row_end && out_col_end;
    item.cls      = cls_code;
  end

  assign push_item = item;
  assign push      = accept && !ignore;
  assign push_col  = in_col_r;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (push) begin
      if (in_col_end) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + dth_pkg::ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
      if (item.emit) begin
        if (item.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (out_col_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + dth_pkg::OUT_ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  `DTH_ASSERT_NEXT(a_frame_restart, push && item.emit && item.last,
    in_col_r == '0 && in_row_r == '0 && out_col_r == '0 && out_row_r == '0,
    "frame end did not clear position counters")
  `DTH_ASSERT_NOW(a_push_needs_room, push, !q_full, "word pushed into a full queue")

endmodule

// ----- rtl/dth_fifo.sv -----
// Short register queue between the front end and the back end.
// No package dependencies; uses the assertion header.
`include "double_threshold_hysteresis_assert.svh"
module dth_fifo #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]     count_r, count_nxt;

  assign full      = count_r == NW'(DEPTH);
  assign not_empty = count_r != '0;
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `DTH_ASSERT_NOW(a_count_bound, 1'b1, count_r <= NW'(DEPTH), "queue count out of range")
  `DTH_ASSERT_NOW(a_no_underflow, pop, not_empty, "pop from an empty queue")

endmodule

// ----- rtl/dth_back.sv -----
// Back end: line store, 3x3 window, hysteresis decision and output register.
// Depends on dth_pkg, dth_ram and the assertion header.
`include "double_threshold_hysteresis_assert.svh"
module dth_back #(
  parameter int MAX_WIDTH = dth_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     strong_val,
  input  logic [7:0]     weak_val,
  input  logic           q_not_empty,
  input  dth_pkg::item_t q_item,
  input  logic [CW-1:0]  q_col,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     edge_value,
  output logic           last_of_frame
);

  logic           s2_valid_r, s2_valid_nxt;
  dth_pkg::item_t s2_item_r;
  logic [CW-1:0]  s2_col_r;
  logic           use_byp_r, use_byp_nxt;
  logic [15:0]    byp_data_r;
  logic [7:0]     win_r [3][2];
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_data_r;
  logic           out_last_r;

  logic        s2_adv, strong_near;
  logic [15:0] rd_pair, pair, wr_pair;
  logic [7:0]  cls, up1, up2, center, value;

  assign s2_adv = s2_valid_r && (!s2_item_r.emit || !out_valid_r || out_tready);
  assign pop    = q_not_empty && (!s2_valid_r || s2_adv);

  // line store entry per column: {two rows up, one row up}
  dth_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_line_store (
    .clk     (clk),
    .wr_en   (s2_adv),
    .wr_addr (s2_col_r),
    .wr_data (wr_pair),
    .rd_en   (pop),
    .rd_addr (q_col),
    .rd_data (rd_pair)
  );

  // map the front's class code onto the configured mark values
  always_comb begin
    unique case (s2_item_r.cls)
      dth_pkg::CLS_STRONG: cls = strong_val;
      dth_pkg::CLS_WEAK:   cls = weak_val;
      default:             cls = 8'd0;
    endcase
  end

  assign pair    = use_byp_r ? byp_data_r : rd_pair;
  assign up1     = s2_item_r.up1_ok ? pair[7:0]  : 8'd0;
  assign up2     = s2_item_r.up2_ok ? pair[15:8] : 8'd0;
  assign wr_pair = {up1, cls};

  // back-to-back words on the same column (one-pixel rows) read stale RAM data
  assign use_byp_nxt = pop ? (s2_adv && (s2_col_r == q_col)) : (s2_adv ? 1'b0 : use_byp_r);

  assign center = win_r[1][1];
  assign strong_near = (win_r[0][0] == strong_val) || (win_r[0][1] == strong_val) ||
                       (up2 == strong_val) || (win_r[1][0] == strong_val) ||
                       (up1 == strong_val) || (win_r[2][0] == strong_val) ||
                       (win_r[2][1] == strong_val) || (cls == strong_val);

  always_comb begin
    if (s2_item_r.interior && (center == weak_val)) begin
      value = strong_near ? strong_val : 8'd0;
    end else begin
      value = center;
    end
  end

  assign s2_valid_nxt  = pop ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_r);
  assign out_valid_nxt = (s2_adv && s2_item_r.emit) ? 1'b1 :
                         (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      use_byp_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= 8'd0;
        win_r[r][1] <= 8'd0;
      end
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      use_byp_r   <= use_byp_nxt;
      out_valid_r <= out_valid_nxt;
      if (s2_adv) begin
        win_r[0][0] <= win_r[0][1];
        win_r[1][0] <= win_r[1][1];
        win_r[2][0] <= win_r[2][1];
        win_r[0][1] <= up2;
        win_r[1][1] <= up1;
        win_r[2][1] <= cls;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_item_r  <= q_item;
      s2_col_r   <= q_col;
      byp_data_r <= wr_pair;
    end
    if (s2_adv && s2_item_r.emit) begin
      out_data_r <= value;
      out_last_r <= s2_item_r.last;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign edge_value    = out_data_r;
  assign last_of_frame = out_last_r;

  `DTH_ASSERT_NEXT(a_stage_holds, s2_valid_r && !s2_adv, s2_valid_r,
    "stalled window stage lost its word")
  `DTH_ASSERT_NOW(a_bypass_has_word, use_byp_r, s2_valid_r,
    "bypass selected with no word in the window stage")
  `DTH_ASSERT_NEXT(a_emit_reaches_out, s2_adv && s2_item_r.emit, out_valid_r,
    "result word did not reach the output register")

endmodule

// ----- rtl/double_threshold_hysteresis.sv -----
// Top level: configuration registers, front end, queue and back end.
// Depends on dth_pkg, dth_front, dth_fifo, dth_back and dth_ram.
//
//  port group  dir  tdata            tuser / tlast
//  in_*        in   pixel_value[7:0] tuser[0] = drain
//  out_*       out  edge_value[7:0]  tlast = last_of_frame
//  cfg_*       in   cfg_wr_data: register value, cfg_addr: register index
//
// One word per clock in steady state while neither side stalls; a result is registered
// through the queue write, the line-store read and the output register.
// The line-store RAM port pair (one read, one write per cycle) sets the rate.
// Reset clears counters, queue and window; line-store contents are not cleared.
// Either side may stall independently; the queue and output register absorb it.
module double_threshold_hysteresis #(
  parameter int MAX_WIDTH   = dth_pkg::MAX_WIDTH_DEF,
  parameter int QUEUE_DEPTH = dth_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] pixel_value
  input  logic [0:0]  in_tuser,     // [0] drain
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] edge_value
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [11:0] cfg_wr_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int IW = $bits(dth_pkg::item_t);

  logic [8:0]  low_r, low_nxt, high_r, high_nxt;
  logic [7:0]  strong_r, strong_nxt, weak_r, weak_nxt;
  logic [CW:0] width_r, width_nxt;
  logic [11:0] height_r, height_nxt;

  logic           push, q_full, pop, q_not_empty;
  dth_pkg::item_t push_item, q_item;
  logic [CW-1:0]  push_col, q_col;
  logic [CW+IW-1:0] q_head;

  always_comb begin
    low_nxt    = low_r;
    high_nxt   = high_r;
    strong_nxt = strong_r;
    weak_nxt   = weak_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr_en) begin
      unique case (dth_pkg::cfg_reg_t'(cfg_addr))
        dth_pkg::REG_LOW:    low_nxt    = cfg_wr_data[8:0];
        dth_pkg::REG_HIGH:   high_nxt   = cfg_wr_data[8:0];
        dth_pkg::REG_STRONG: strong_nxt = cfg_wr_data[7:0];
        dth_pkg::REG_WEAK:   weak_nxt   = cfg_wr_data[7:0];
        dth_pkg::REG_WIDTH:  width_nxt  = (CW+1)'(dth_pkg::clamp_dim(cfg_wr_data,
                                           dth_pkg::DIM_W'(MAX_WIDTH)));
        dth_pkg::REG_HEIGHT: height_nxt = 12'(dth_pkg::clamp_dim(cfg_wr_data,
                                           dth_pkg::DIM_W'(dth_pkg::MAX_HEIGHT)));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r    <= dth_pkg::LOW_RST;
      high_r   <= dth_pkg::HIGH_RST;
      strong_r <= dth_pkg::STRONG_RST;
      weak_r   <= dth_pkg::WEAK_RST;
      width_r  <= (CW+1)'(dth_pkg::clamp_dim(dth_pkg::WIDTH_RST,
                  dth_pkg::DIM_W'(MAX_WIDTH)));
      height_r <= 12'(dth_pkg::clamp_dim(dth_pkg::HEIGHT_RST,
                  dth_pkg::DIM_W'(dth_pkg::MAX_HEIGHT)));
    end else begin
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      strong_r <= strong_nxt;
      weak_r   <= weak_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  dth_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .pixel_value (in_tdata),
    .drain       (in_tuser[0]),
    .low_thr     (low_r),
    .high_thr    (high_r),
    .width       (width_r),
    .height      (height_r),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item),
    .push_col    (push_col)
  );

  dth_fifo #(.DATA_W(CW + IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_col, push_item}),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_data (q_head)
  );

  assign q_item = dth_pkg::item_t'(q_head[IW-1:0]);
  assign q_col  = q_head[CW+IW-1:IW];

  dth_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .strong_val    (strong_r),
    .weak_val      (weak_r),
    .q_not_empty   (q_not_empty),
    .q_item        (q_item),
    .q_col         (q_col),
    .pop           (pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .edge_value    (out_tdata),
    .last_of_frame (out_tlast)
  );

endmodule

// ----- tb/sv/double_threshold_hysteresis_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for double_threshold_hysteresis: a short directed frame, then random frames.
// An in-bench model of classification and hysteresis predicts every result word.
// Depends on dth_pkg and the double_threshold_hysteresis RTL.
module double_threshold_hysteresis_tb;

  localparam int LINE_MAX      = 2048;
  localparam int HEIGHT_MAX    = 2048;
  localparam int ROW_CAP       = 65535;
  localparam int STALL_LIMIT   = 2000;
  localparam int SMALL_WORDS   = 1800;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_MAX    = 10;
  localparam int DIRECTED_ROWS = 18;

  typedef struct packed {
    logic [7:0] edge_val;
    logic       last;
  } edge_word_t;

  typedef struct packed {
    logic [7:0] pix;
    logic       drn;
    logic       typed;   // expected result typed in below
    logic [7:0] t_val;
    logic       t_last;
  } stim_row_t;

  typedef logic [11:0] reg_set_t [6];

  // 4x3 frame, low 20 / high 50; results lag frame_width+1 words, so the
  // typed value on a row belongs to the pixel five words earlier
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'd0,   1'b1, 1'b0, 8'd0,   1'b0},  // drain while pixels are due: ignored
    '{8'd255, 1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd20,  1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd19,  1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd50,  1'b0, 1'b0, 8'd0,   1'b0},
    '{8'd49,  1'b0, 1'b1, 8'd255, 1'b0},
    '{8'd20,  1'b0, 1'b1, 8'd128, 1'b0},  // weak on the top border stays weak
    '{8'd19,  1'b0, 1'b1, 8'd0,   1'b0},
    '{8'd255, 1'b0, 1'b1, 8'd0,   1'b0},
    '{8'd19,  1'b0, 1'b1, 8'd255, 1'b0},
    '{8'd20,  1'b0, 1'b0, 8'd0,   1'b0},  // interior, strong neighbor
    '{8'd0,   1'b0, 1'b0, 8'd0,   1'b0},  // interior, no strong neighbor
    '{8'd255, 1'b1, 1'b1, 8'd0,   1'b0},
    '{8'd255, 1'b0, 1'b1, 8'd255, 1'b0},  // pixel past the frame acts as drain
    '{8'd0,   1'b1, 1'b1, 8'd0,   1'b0},
    '{8'd0,   1'b1, 1'b1, 8'd128, 1'b0},
    '{8'd0,   1'b1, 1'b1, 8'd0,   1'b1}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;     // [7:0] pixel_value
  logic [0:0]  in_tuser = 1'b0;     // [0] drain
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;           // [7:0] edge_value
  logic        out_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_addr = 3'd0;
  logic [11:0] cfg_wr_data = 12'd0;

  always #5 clk = ~clk;

  double_threshold_hysteresis i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data)
  );

  // model state and its copy of the registers
  logic [8:0]  thr_lo, thr_hi;
  logic [7:0]  val_strong, val_weak;
  logic [11:0] frame_w_reg, frame_h_reg;
  logic [7:0]  row1_cls [LINE_MAX];
  logic [7:0]  row2_cls [LINE_MAX];
  logic [7:0]  win [3][3];
  int unsigned src_col, src_row, dst_col, dst_row;

  edge_word_t  pending_edges[$];
  int unsigned quiet_cycles = 0;
  int unsigned edges_seen = 0;
  int unsigned live_words = 0;
  int          mismatches = 0;
  logic        frame_done = 1'b0;
  logic        calm = 1'b0;
  logic        typed_on = 1'b0;
  logic [7:0]  typed_val = 8'd0;
  logic        typed_last = 1'b0;

  function automatic int unsigned eff_dim(input logic [11:0] v, input int unsigned lim);
    if (v == 12'd0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  task automatic hysteresis_step(input logic [7:0] pix, input logic drn,
                                 output logic emit, output edge_word_t res);
    int unsigned w, h, col;
    int          r, i, j;
    logic        drain_phase, strong_near;
    logic [7:0]  cls, up1, up2, center;
    w = eff_dim(frame_w_reg, LINE_MAX);
    h = eff_dim(frame_h_reg, HEIGHT_MAX);
    emit = 1'b0;
    res = '0;
    drain_phase = (src_row >= h);
    if (drn && !drain_phase) return;
    if (drain_phase) begin
      cls = 8'd0;
    end else if (pix >= thr_hi) begin
      cls = val_strong;
    end else if (pix >= thr_lo) begin
      cls = val_weak;
    end else begin
      cls = 8'd0;
    end
    col = src_col % LINE_MAX;
    up1 = (src_row >= 1) ? row1_cls[col] : 8'd0;
    up2 = (src_row >= 2) ? row2_cls[col] : 8'd0;
    row2_cls[col] = up1;
    row1_cls[col] = cls;
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = cls;
    emit = (src_row >= 2) || (src_row == 1 && src_col >= 1);
    if (src_col + 1 >= w) begin
      src_col = 0;
      if (src_row < ROW_CAP) src_row++;
    end else begin
      src_col++;
    end
    if (!emit) return;
    center = win[1][1];
    res.edge_val = center;
    if (dst_row >= 1 && dst_row + 2 <= h && dst_col >= 1 && dst_col + 2 <= w &&
        center == val_weak) begin
      strong_near = 1'b0;
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          if (!(i == 1 && j == 1) && win[i][j] == val_strong) strong_near = 1'b1;
        end
      end
      res.edge_val = strong_near ? val_strong : 8'd0;
    end
    res.last = (dst_row + 1 >= h) && (dst_col + 1 >= w);
    if (res.last) begin
      src_col = 0;
      src_row = 0;
      dst_col = 0;
      dst_row = 0;
    end else if (dst_col + 1 >= w) begin
      dst_col = 0;
      if (dst_row < ROW_CAP) dst_row++;
    end else begin
      dst_col++;
    end
  endtask

  function automatic void flag_edge(input string why, input edge_word_t want);
    if (mismatches < REPORT_MAX) begin
      $display("%0t: edge word %0d %s: expected value %0d last %0b, got value %0d last %0b",
               $time, edges_seen, why, want.edge_val, want.last, out_tdata, out_tlast);
    end
    mismatches++;
  endfunction

  always @(posedge clk) begin
    logic       emit;
    edge_word_t res, want;
    if (in_tvalid && in_tready) begin
      hysteresis_step(in_tdata, in_tuser[0], emit, res);
      if (emit) begin
        if (res.last) frame_done = 1'b1;
        if (typed_on) begin
          res.edge_val = typed_val;
          res.last = typed_last;
        end
        pending_edges.push_back(res);
      end
    end
    if (out_tvalid && out_tready) begin
      if (pending_edges.size() == 0) begin
        flag_edge("unexpected", '0);
      end else begin
        want = pending_edges.pop_front();
        if (want.edge_val !== out_tdata || want.last !== out_tlast) flag_edge("wrong", want);
      end
      edges_seen++;
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
  end

  // receiver: ready bursts, mostly short stalls, now and then a long one
  int unsigned rdy_left = 0;
  always @(negedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (rdy_left != 0) begin
      rdy_left--;
    end else if (!out_tready) begin
      out_tready <= 1'b1;
      rdy_left = $urandom_range(1, 20);
    end else begin
      out_tready <= 1'b0;
      rdy_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 15);
    if (r < 10) return 0;
    if (r < 14) return $urandom_range(1, 3);
    if (r < 15) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_pixel();
    int t;
    unique case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: begin
        // land on or just below a threshold
        t = $urandom_range(0, 1) ? int'(thr_lo) : int'(thr_hi);
        t = t - int'($urandom_range(0, 1));
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return 8'(t);
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [11:0] pick_thr();
    unique case ($urandom_range(0, 5))
      0: return 12'd0;
      1: return 12'd256;
      default: return 12'($urandom_range(0, 256));
    endcase
  endfunction

  function automatic logic [11:0] pick_val();
    unique case ($urandom_range(0, 4))
      0: return 12'd0;
      1: return 12'd255;
      default: return 12'($urandom_range(0, 255));
    endcase
  endfunction

  // call at a falling edge; returns at the edge that takes the word
  task automatic drive_word(input logic [7:0] pix, input logic drn);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pix;
    in_tuser <= drn;
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  // call at a falling edge; one write per cycle, enable dropped after the last
  task automatic apply_config(input reg_set_t v);
    dth_pkg::cfg_reg_t order [6];
    int                k;
    order = '{dth_pkg::REG_LOW, dth_pkg::REG_HIGH, dth_pkg::REG_STRONG,
              dth_pkg::REG_WEAK, dth_pkg::REG_WIDTH, dth_pkg::REG_HEIGHT};
    for (k = 0; k < 6; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr <= order[k];
      cfg_wr_data <= v[k];
      unique case (order[k])
        dth_pkg::REG_LOW:    thr_lo = v[k][8:0];
        dth_pkg::REG_HIGH:   thr_hi = v[k][8:0];
        dth_pkg::REG_STRONG: val_strong = v[k][7:0];
        dth_pkg::REG_WEAK:   val_weak = v[k][7:0];
        dth_pkg::REG_WIDTH:  frame_w_reg = v[k];
        dth_pkg::REG_HEIGHT: frame_h_reg = v[k];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // hold input, wait for all results plus pipeline latency
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one whole frame with noise: stray drains while pixels are due, stray pixels after
  task automatic run_frame();
    logic [7:0]  pix;
    logic        drn;
    logic        due;
    int unsigned h;
    frame_done = 1'b0;
    while (!frame_done) begin
      h = eff_dim(frame_h_reg, HEIGHT_MAX);
      due = (src_row < h);
      drn = due ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 9) != 0);
      pix = pick_pixel();
      if (!(due && drn)) live_words++;
      drive_word(pix, drn);
      @(negedge clk);
    end
  endtask

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    reg_set_t    v;
    int          n;
    int unsigned nframes;
    thr_lo = dth_pkg::LOW_RST;
    thr_hi = dth_pkg::HIGH_RST;
    val_strong = dth_pkg::STRONG_RST;
    val_weak = dth_pkg::WEAK_RST;
    frame_w_reg = dth_pkg::WIDTH_RST;
    frame_h_reg = dth_pkg::HEIGHT_RST;
    foreach (row1_cls[k]) begin
      row1_cls[k] = 8'd0;
      row2_cls[k] = 8'd0;
    end
    foreach (win[r, c]) win[r][c] = 8'd0;
    src_col = 0;
    src_row = 0;
    dst_col = 0;
    dst_row = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    v = '{12'd20, 12'd50, 12'd255, 12'd128, 12'd4, 12'd3};
    apply_config(v);
    for (n = 0; n < DIRECTED_ROWS; n++) begin
      typed_on = DIRECTED[n].typed;
      typed_val = DIRECTED[n].t_val;
      typed_last = DIRECTED[n].t_last;
      drive_word(DIRECTED[n].pix, DIRECTED[n].drn);
      @(negedge clk);
    end
    typed_on = 1'b0;
    settle();

    while (live_words < SMALL_WORDS) begin
      v[0] = pick_thr();
      v[1] = pick_thr();
      v[2] = pick_val();
      v[3] = ($urandom_range(0, 3) == 0) ? v[2] : pick_val();
      v[4] = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 9));
      v[5] = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 7));
      calm = ($urandom_range(0, 3) == 0);
      apply_config(v);
      nframes = $urandom_range(1, 4);
      repeat (nframes) run_frame();
      settle();
    end

    // zero width with zero height, then zero width with a taller strip
    calm = 1'b0;
    v = '{12'd30, 12'd120, 12'd200, 12'd90, 12'd0, 12'd0};
    apply_config(v);
    run_frame();
    settle();
    v = '{12'd0, 12'd256, 12'd255, 12'd0, 12'd0, 12'd12};
    apply_config(v);
    run_frame();
    settle();

    if (mismatches == 0 && pending_edges.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
